/* src/mvt_pkg.sv */
// Shared types, widths and constants for the 4x4 matrix-vector transform.
package mvt_pkg;

    localparam int ELEM_W          = 32;
    localparam int NUM_ELEMS       = 4;
    localparam int PROD_W          = 2 * ELEM_W;
    localparam int PAIR_W          = PROD_W + 1;
    localparam int SUM_W           = PROD_W + 2;
    localparam int CFG_W           = 2 * ELEM_W;
    localparam int NUM_REGS        = 8;
    localparam int CFG_IDX_W       = $clog2(NUM_REGS);
    localparam int VEC_W           = NUM_ELEMS * ELEM_W;
    localparam int NUM_STAGES      = 4;
    localparam int FRAC_BITS_DEF   = 16;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t [NUM_ELEMS-1:0]    vec_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef sum_t [NUM_ELEMS-1:0]     sum_vec_t;
    typedef logic [CFG_W-1:0]         cfg_word_t;

    // Load enables for the three lane stages
    typedef struct packed {
        logic prod_ld;
        logic pair_ld;
        logic sum_ld;
    } lane_ctl_t;

    // Reset contents of one matrix register: the identity matrix.
    // Registers 0 and 5 carry a one in the low row, 2 and 7 in the high row.
    function automatic cfg_word_t identity_word(input int idx, input int frac_bits);
        cfg_word_t one;
        cfg_word_t word;
        one  = cfg_word_t'(1) << frac_bits;
        word = '0;
        if (idx == 0 || idx == 5) begin
            word = one;
        end else if (idx == 2 || idx == 7) begin
            word = one << ELEM_W;
        end
        return word;
    endfunction

endpackage

/* src/matrix_vector_transform_4x4.sv */
// Top level of the 4x4 fixed-point matrix-vector transform.
//
//   channel  direction  beat contents
//   s_       in         tdata = in_x, in_y, in_z, in_w (32 bits each, low first)
//   m_       out        tdata = out_x, out_y, out_z, out_w (32 bits each, low first)
//   cfg_     in         write of one 64-bit matrix register, no read-back
//
// One vector per cycle sustained while the output is not stalled; each beat passes
// through the product, pair-sum, row-sum and round/saturate registers to the output.
// Four row lanes run side by side, each with its own four multipliers.
// Reset loads the identity matrix and empties the pipeline.
// A stalled output holds its beat; stages behind it keep filling their bubbles.
module matrix_vector_transform_4x4
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VEC_W-1:0]     s_tdata,   // in_x, in_y, in_z, in_w
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VEC_W-1:0]     m_tdata,   // out_x, out_y, out_z, out_w
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_word_t              matrix_reg [NUM_REGS];
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  valid_next;
    logic [NUM_STAGES-1:0]  stage_rdy;
    vec_t                   in_vec;
    vec_t                   rows [NUM_ELEMS];
    sum_vec_t               sums;
    lane_ctl_t              lane_ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                matrix_reg[i] <= identity_word(i, FRAC_BITS);
            end
        end else if (cfg_wr_en) begin
            matrix_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Row r, column c lives in register 2c + r/2, upper half for odd rows
    for (genvar r = 0; r < NUM_ELEMS; r++) begin : g_row
        for (genvar c = 0; c < NUM_ELEMS; c++) begin : g_col
            assign rows[r][c] = matrix_reg[2*c + r/2][ELEM_W*(r%2) +: ELEM_W];
        end
    end

    // A stage may load when it is empty or the stage after it moves on
    always_comb begin
        stage_rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES-2; k >= 0; k--) begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        valid_next[0] = stage_rdy[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = stage_rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign lane_ctl.prod_ld = stage_rdy[0] && s_tvalid;
    assign lane_ctl.pair_ld = stage_rdy[1] && valid_reg[0];
    assign lane_ctl.sum_ld  = stage_rdy[2] && valid_reg[1];

    assign in_vec = s_tdata;

    for (genvar r = 0; r < NUM_ELEMS; r++) begin : g_lane
        mvt_lane u_lane (
            .aclk (aclk),
            .vec  (in_vec),
            .row  (rows[r]),
            .ctl  (lane_ctl),
            .sum  (sums[r])
        );
    end

    mvt_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .aclk  (aclk),
        .ld    (stage_rdy[NUM_STAGES-1] && valid_reg[NUM_STAGES-2]),
        .sums  (sums),
        .tdata (m_tdata)
    );

    assign s_tready = stage_rdy[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted beat did not enter the first stage");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted with a full, stalled pipeline");

    a_stall_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !(s_tvalid && s_tready))
            |=> $countones(valid_reg) == $past($countones(valid_reg)))
        else $error("beat lost or created inside a stalled pipeline");

endmodule

/* src/mvt_lane.sv */
// One row lane: four products, pairwise sums, then the full exact row sum.
module mvt_lane
    import mvt_pkg::*;
(
    input  logic      aclk,
    input  vec_t      vec,
    input  vec_t      row,
    input  lane_ctl_t ctl,
    output sum_t      sum
);

    prod_t prod_reg [NUM_ELEMS];
    pair_t pair_reg [NUM_ELEMS/2];
    sum_t  sum_reg;

    always_ff @(posedge aclk) begin
        if (ctl.prod_ld) begin
            for (int c = 0; c < NUM_ELEMS; c++) begin
                prod_reg[c] <= prod_t'(vec[c]) * prod_t'(row[c]);
            end
        end
        if (ctl.pair_ld) begin
            for (int p = 0; p < NUM_ELEMS/2; p++) begin
                pair_reg[p] <= pair_t'(prod_reg[2*p]) + pair_t'(prod_reg[2*p+1]);
            end
        end
        if (ctl.sum_ld) begin
            sum_reg <= sum_t'(pair_reg[0]) + sum_t'(pair_reg[1]);
        end
    end

    assign sum = sum_reg;

endmodule

/* src/mvt_merge.sv */
// Merge stage: round and saturate each lane's row sum into the output beat.
module mvt_merge
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           aclk,
    input  logic           ld,
    input  sum_vec_t       sums,
    output logic [VEC_W-1:0] tdata
);

    localparam sum_t RND = sum_t'(1) << (FRAC_BITS - 1);

    vec_t out_reg;
    vec_t out_next;

    always_comb begin
        sum_t                 rounded;
        sum_t                 shifted;
        logic [SUM_W-ELEM_W:0] hi;
        out_next = '0;
        for (int r = 0; r < NUM_ELEMS; r++) begin
            rounded = sums[r] + RND;
            shifted = rounded >>> FRAC_BITS;
            hi      = shifted[SUM_W-1:ELEM_W-1];
            if (&hi || ~|hi) begin
                out_next[r] = shifted[ELEM_W-1:0];
            end else if (shifted[SUM_W-1]) begin
                out_next[r] = {1'b1, {(ELEM_W-1){1'b0}}};
            end else begin
                out_next[r] = {1'b0, {(ELEM_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            out_reg <= out_next;
        end
    end

    assign tdata = out_reg;

endmodule

/* dv/matrix_vector_transform_4x4_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the 4x4 fixed-point matrix-vector transform.
module matrix_vector_transform_4x4_test;
    import mvt_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int RAND_ITEMS = 1150;
    localparam int STALL_PCT  = 21;
    localparam int WATCHDOG   = 2000;
    localparam int SETTLE     = 8;

    localparam elem_t Q_ONE  = elem_t'(1) << FRAC;
    localparam elem_t Q_HALF = elem_t'(1) << (FRAC - 1);
    localparam elem_t Q_MAX  = 32'sh7FFF_FFFF;
    localparam elem_t Q_MIN  = 32'sh8000_0000;
    localparam elem_t CORNERS [8] = '{Q_MAX, Q_MIN, 32'sh0, -32'sh1, 32'sh1,
                                      Q_ONE, -Q_ONE, Q_HALF};

    localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (FRAC - 1);
    localparam logic signed [127:0] WIDE_MAX   = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] WIDE_MIN   = -128'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        COL0_ROWS01, COL0_ROWS23, COL1_ROWS01, COL1_ROWS23,
        COL2_ROWS01, COL2_ROWS23, COL3_ROWS01, COL3_ROWS23
    } matrix_reg_e;

    typedef enum int {
        MAT_RANDOM, MAT_SMALL, MAT_MIXED, MAT_FULL_POS,
        MAT_FULL_NEG, MAT_HALF, MAT_PARTIAL
    } matrix_style_e;

    class transform_scoreboard;
        cfg_word_t matrix_regs [NUM_REGS];
        vec_t      expected_q [$];
        int        errors;
        string     field_name [NUM_ELEMS] = '{"out_x", "out_y", "out_z", "out_w"};

        function new();
            errors = 0;
            for (int i = 0; i < NUM_REGS; i++) begin
                case (matrix_reg_e'(i)) inside
                    COL0_ROWS01, COL2_ROWS23: matrix_regs[i] = {32'h0, Q_ONE};
                    COL1_ROWS01, COL3_ROWS23: matrix_regs[i] = {Q_ONE, 32'h0};
                    default:                  matrix_regs[i] = '0;
                endcase
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t value);
            matrix_regs[idx] = value;
        endfunction

        // Column-major: two rows of one column per register, low row in low half
        function elem_t entry_at(int row, int col);
            cfg_word_t word;
            word = matrix_regs[col * 2 + row / 2];
            return (row % 2 == 1) ? word[2*ELEM_W-1:ELEM_W] : word[ELEM_W-1:0];
        endfunction

        function elem_t transform_row(int row, vec_t vec);
            logic signed [127:0] acc;
            logic signed [127:0] lhs;
            logic signed [127:0] rhs;
            elem_t a;
            elem_t b;
            acc = ROUND_HALF;
            for (int col = 0; col < NUM_ELEMS; col++) begin
                a   = entry_at(row, col);
                b   = vec[col];
                lhs = a;
                rhs = b;
                acc = acc + lhs * rhs;
            end
            acc = acc >>> FRAC;
            if (acc > WIDE_MAX) return Q_MAX;
            if (acc < WIDE_MIN) return Q_MIN;
            return acc[ELEM_W-1:0];
        endfunction

        function void note_input(vec_t vec);
            vec_t result;
            for (int r = 0; r < NUM_ELEMS; r++) begin
                result[r] = transform_row(r, vec);
            end
            expected_q.push_back(result);
        endfunction

        function void check_result(vec_t got);
            vec_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat %h arrived with nothing expected", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            for (int f = 0; f < NUM_ELEMS; f++) begin
                if (got[f] !== want[f]) begin
                    $display("%0t: %s expected %h got %h", $time, field_name[f],
                             want[f], got[f]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    vec_t                 s_tdata   = '0;   // in_x, in_y, in_z, in_w
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    vec_t                 m_tdata;          // out_x, out_y, out_z, out_w
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    cfg_word_t            cfg_wdata = '0;

    bit                   steady    = 1'b0;
    int                   quiet_cycles = 0;
    transform_scoreboard  sb;

    matrix_vector_transform_4x4 #(
        .FRAC_BITS(FRAC)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= aresetn && (steady || $urandom_range(99) >= STALL_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) sb.write_reg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) sb.note_input(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("matrix_vector_transform_4x4_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic vec_t pack_vector(elem_t x, elem_t y, elem_t z, elem_t w);
        return {w, z, y, x};
    endfunction

    // Roughly +/-8.0, the range of typical transform entries and coordinates
    function automatic elem_t small_elem();
        return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic elem_t pick_elem();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return CORNERS[$urandom_range(7)];
        if (roll <= 4) return $urandom;
        return small_elem();
    endfunction

    function automatic vec_t random_vector();
        vec_t vec;
        for (int k = 0; k < NUM_ELEMS; k++) begin
            vec[k] = pick_elem();
        end
        return vec;
    endfunction

    // Idle a random number of single cycles, then hold the beat until taken
    task automatic send_vector(input vec_t vec);
        while (!steady && $urandom_range(99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= vec;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off until every result is back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic program_matrix(input matrix_style_e style);
        matrix_reg_e order [NUM_REGS];
        matrix_reg_e swap;
        cfg_word_t   word;
        int          count;
        int          j;
        for (int i = 0; i < NUM_REGS; i++) order[i] = matrix_reg_e'(i);
        for (int i = NUM_REGS - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        count = (style == MAT_PARTIAL) ? $urandom_range(1, NUM_REGS - 1) : NUM_REGS;
        for (int i = 0; i < count; i++) begin
            case (style) inside
                MAT_FULL_POS: word = {Q_MAX, Q_MAX};
                MAT_FULL_NEG: word = {Q_MIN, Q_MIN};
                MAT_HALF:     word = {Q_HALF, Q_HALF};
                MAT_SMALL:    word = {small_elem(), small_elem()};
                MAT_MIXED,
                MAT_PARTIAL:  word = {pick_elem(), pick_elem()};
                default:      word = {$urandom, $urandom};
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= word;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int sent;
        int phase;
        int phase_len;
        matrix_style_e style;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity out of reset: each beat comes back unchanged
        send_vector(pack_vector(32'sh0, 32'sh0, 32'sh0, 32'sh0));
        send_vector(pack_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_vector(pack_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_vector(pack_vector(32'sh1, -32'sh1, Q_ONE, -Q_ONE));
        send_vector(pack_vector(-32'sh1, -32'sh1, -32'sh1, -32'sh1));
        send_vector(pack_vector(Q_MAX, Q_MIN, 32'sh0, 32'sh1));
        send_vector(pack_vector(Q_HALF, -Q_HALF, 32'sh5555_5555, 32'shAAAA_AAAA));

        // Full-scale entries: saturation both ways
        drain();
        program_matrix(MAT_FULL_POS);
        send_vector(pack_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_vector(pack_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_vector(pack_vector(Q_ONE, -Q_ONE, Q_ONE, -Q_ONE));
        send_vector(pack_vector(32'sh1, 32'sh0, 32'sh0, 32'sh0));

        // Most negative squared four times overflows 64 bits
        drain();
        program_matrix(MAT_FULL_NEG);
        send_vector(pack_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_vector(pack_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_vector(pack_vector(-32'sh1, 32'sh0, 32'sh0, 32'sh0));

        // Half entries: exact ties round up toward plus infinity
        drain();
        program_matrix(MAT_HALF);
        send_vector(pack_vector(32'sh1, 32'sh0, 32'sh0, 32'sh0));
        send_vector(pack_vector(-32'sh1, 32'sh0, 32'sh0, 32'sh0));
        send_vector(pack_vector(32'sh1, 32'sh1, 32'sh1, 32'sh0));
        send_vector(pack_vector(-32'sh3, 32'sh0, 32'sh0, 32'sh0));
        send_vector(pack_vector(32'sh1, 32'sh1, 32'sh1, 32'sh1));

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            drain();
            style = (phase == 0) ? MAT_RANDOM
                                 : matrix_style_e'($urandom_range(MAT_PARTIAL));
            program_matrix(style);
            steady    = (phase == 3);
            phase_len = steady ? 200 : $urandom_range(40, 140);
            repeat (phase_len) begin
                send_vector(random_vector());
                sent++;
            end
            steady = 1'b0;
            phase++;
        end
        drain();

        if (sb.errors == 0) begin
            $display("matrix_vector_transform_4x4_test OK");
        end else begin
            $display("matrix_vector_transform_4x4_test NOT OK");
        end
        $finish;
    end

endmodule
